[rtl/snu_pkg.sv]
// snu_pkg: shared types and constants of the sphere normal to uv mapper
// holds the cordic angle table, parameter defaults and the tag carried down the cell chain
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package snu_pkg;

	// parameter defaults
	localparam int DEF_CORDIC_STAGES = 16;
	localparam int DEF_COORD_WIDTH   = 16;

	// io widths fixed by the item format
	localparam int IO_WIDTH  = 16;
	localparam int ACC_WIDTH = 32;

	// one half turn (pi) in units of 2^-32 turn, a full turn (2 pi) wraps to zero
	localparam logic [ACC_WIDTH-1:0] ACC_PI = 32'h8000_0000;

	// rounding bias for the 16 bit u result
	localparam logic [ACC_WIDTH-1:0] ACC_ROUND = 32'h0000_8000;

	// atan(2^-i) in units of 2^-32 turn
	localparam int ANGLE_TABLE_LEN = 24;
	localparam logic [ACC_WIDTH-1:0] ANGLE_STEP [ANGLE_TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// side data that rides along with each request
	typedef struct packed {
		logic                zero;
		logic [IO_WIDTH-1:0] tex_v;
	} snu_tag_t;

endpackage

`default_nettype wire

[rtl/snu_norm_if.sv]
// snu_norm_if: valid/ready channel carrying one unit normal request
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface snu_norm_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;

	modport source (output valid, output norm_x, output norm_y, output norm_z, input ready);
	modport sink   (input valid, input norm_x, input norm_y, input norm_z, output ready);
endinterface

`default_nettype wire

[rtl/snu_uv_if.sv]
// snu_uv_if: valid/ready channel carrying one texture coordinate request
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface snu_uv_if;
	logic        valid;
	logic        ready;
	logic [15:0] tex_u;
	logic [15:0] tex_v;

	modport source (output valid, output tex_u, output tex_v, input ready);
	modport sink   (input valid, input tex_u, input tex_v, output ready);
endinterface

`default_nettype wire

[rtl/snu_prep.sv]
// snu_prep: input stage, scales the normal to cordic width, folds the left half plane
// and computes v; depends on snu_pkg
`timescale 1ns / 1ps
`default_nettype none

module snu_prep #(
	parameter int COORD_WIDTH = 16
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire signed [snu_pkg::IO_WIDTH-1:0]     norm_x,
	input  wire signed [snu_pkg::IO_WIDTH-1:0]     norm_y,
	input  wire signed [snu_pkg::IO_WIDTH-1:0]     norm_z,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic signed [COORD_WIDTH+2:0]          re,
	output logic signed [COORD_WIDTH+2:0]          im,
	output logic [snu_pkg::ACC_WIDTH-1:0]          acc,
	output snu_pkg::snu_tag_t                      tag
);
	import snu_pkg::*;

	localparam int W  = COORD_WIDTH + 3;
	localparam int UP = (COORD_WIDTH >= IO_WIDTH) ? COORD_WIDTH - IO_WIDTH : 0;
	localparam int DN = (COORD_WIDTH < IO_WIDTH) ? IO_WIDTH - COORD_WIDTH : 0;
	localparam int EW = (W > IO_WIDTH) ? W : IO_WIDTH;

	logic signed [EW-1:0]       x_ext, z_ext;
	logic signed [W-1:0]        x_sc, z_sc;
	logic                       zero_c, left_c;
	logic signed [IO_WIDTH:0]   v_full;
	logic [IO_WIDTH-1:0]        v_c;

	logic                       valid_s1;
	logic signed [W-1:0]        re_s1, im_s1;
	logic [ACC_WIDTH-1:0]       acc_s1;
	snu_tag_t                   tag_s1;

	// scale to coordinate width, floor on a right shift
	always_comb begin
		x_ext = EW'(norm_x);
		z_ext = EW'(norm_z);
		x_ext = (x_ext <<< UP) >>> DN;
		z_ext = (z_ext <<< UP) >>> DN;
		x_sc  = x_ext[W-1:0];
		z_sc  = z_ext[W-1:0];
	end

	// zero vector and left half plane detection
	assign zero_c = (x_sc == '0) && (z_sc == '0);
	assign left_c = z_sc[W-1];

	// v = 32768 - y, saturated at the top code
	assign v_full = (IO_WIDTH+1)'(32768) - (IO_WIDTH+1)'(norm_y);
	assign v_c    = v_full[IO_WIDTH] ? '1 : v_full[IO_WIDTH-1:0];

	// stage handshake
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload, turned by a half turn when z is negative
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			re_s1        <= left_c ? -z_sc : z_sc;
			im_s1        <= left_c ? -x_sc : x_sc;
			acc_s1       <= left_c ? ACC_PI : '0;
			tag_s1.zero  <= zero_c;
			tag_s1.tex_v <= v_c;
		end
	end

	assign out_valid = valid_s1;
	assign re        = re_s1;
	assign im        = im_s1;
	assign acc       = acc_s1;
	assign tag       = tag_s1;

endmodule

`default_nettype wire

[rtl/snu_cell.sv]
// snu_cell: one cordic vectoring micro-rotation with its own pipeline register
// depends on snu_pkg
`timescale 1ns / 1ps
`default_nettype none

module snu_cell #(
	parameter int W     = 19,
	parameter int STAGE = 0
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire signed [W-1:0]             in_re,
	input  wire signed [W-1:0]             in_im,
	input  wire [snu_pkg::ACC_WIDTH-1:0]   in_acc,
	input  snu_pkg::snu_tag_t              in_tag,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic signed [W-1:0]            out_re,
	output logic signed [W-1:0]            out_im,
	output logic [snu_pkg::ACC_WIDTH-1:0]  out_acc,
	output snu_pkg::snu_tag_t              out_tag
);
	import snu_pkg::*;

	localparam logic [ACC_WIDTH-1:0] STEP = ANGLE_STEP[STAGE];

	logic signed [W-1:0]  dre, dim;
	logic                 up;
	logic                 valid_q;
	logic signed [W-1:0]  re_q, im_q;
	logic [ACC_WIDTH-1:0] acc_q;
	snu_tag_t             tag_q;

	// shifted cross terms, rotate toward the real axis
	assign dre = in_im >>> STAGE;
	assign dim = in_re >>> STAGE;
	assign up  = !in_im[W-1];

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			re_q  <= up ? in_re + dre : in_re - dre;
			im_q  <= up ? in_im - dim : in_im + dim;
			acc_q <= up ? in_acc + STEP : in_acc - STEP;
			tag_q <= in_tag;
		end
	end

	assign out_valid = valid_q;
	assign out_re    = re_q;
	assign out_im    = im_q;
	assign out_acc   = acc_q;
	assign out_tag   = tag_q;

endmodule

`default_nettype wire

[rtl/snu_out.sv]
// snu_out: rounds the angle accumulator to u and holds the result register
// depends on snu_pkg
`timescale 1ns / 1ps
`default_nettype none

module snu_out (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire [snu_pkg::ACC_WIDTH-1:0]   in_acc,
	input  snu_pkg::snu_tag_t              in_tag,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [snu_pkg::IO_WIDTH-1:0]   tex_u,
	output logic [snu_pkg::IO_WIDTH-1:0]   tex_v
);
	import snu_pkg::*;

	logic [ACC_WIDTH-1:0] acc_sel, acc_rnd;
	logic                 valid_q;
	logic [IO_WIDTH-1:0]  u_q, v_q;

	// zero vector reads as one half turn, then round half up, full turn wraps
	assign acc_sel = in_tag.zero ? ACC_PI : in_acc;
	assign acc_rnd = acc_sel + ACC_ROUND;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			u_q <= acc_rnd[ACC_WIDTH-1 -: IO_WIDTH];
			v_q <= in_tag.tex_v;
		end
	end

	assign out_valid = valid_q;
	assign tex_u     = u_q;
	assign tex_v     = v_q;

endmodule

`default_nettype wire

[rtl/sphere_normal_to_uv.sv]
// sphere_normal_to_uv: unit normal to spherical texture coordinates
// stages: input stage, one cell per micro-rotation (table length caps them), result register
// throughput is one request per cycle while tex.ready is high; every stage holds its request
// under backpressure and fills its bubbles, so the chain of cordic cells sets depth and rate
// reset clears the valid bit of every stage, payload registers are not reset
// depends on snu_pkg, snu_norm_if, snu_uv_if, snu_prep, snu_cell, snu_out
`timescale 1ns / 1ps
`default_nettype none

module sphere_normal_to_uv #(
	parameter int CORDIC_STAGES = snu_pkg::DEF_CORDIC_STAGES,
	parameter int COORD_WIDTH   = snu_pkg::DEF_COORD_WIDTH
) (
	input  wire     clk,
	input  wire     arst_n,
	snu_norm_if.sink  normal,
	snu_uv_if.source  tex
);
	import snu_pkg::*;

	localparam int W = COORD_WIDTH + 3;
	localparam int N = (CORDIC_STAGES < ANGLE_TABLE_LEN) ? CORDIC_STAGES : ANGLE_TABLE_LEN;

	// chain links, index 0 is the input stage output
	logic                 valid_c [N+1];
	logic                 ready_c [N+1];
	logic signed [W-1:0]  re_c    [N+1];
	logic signed [W-1:0]  im_c    [N+1];
	logic [ACC_WIDTH-1:0] acc_c   [N+1];
	snu_tag_t             tag_c   [N+1];

	// input stage
	snu_prep #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (normal.valid),
		.in_ready  (normal.ready),
		.norm_x    (normal.norm_x),
		.norm_y    (normal.norm_y),
		.norm_z    (normal.norm_z),
		.out_valid (valid_c[0]),
		.out_ready (ready_c[0]),
		.re        (re_c[0]),
		.im        (im_c[0]),
		.acc       (acc_c[0]),
		.tag       (tag_c[0])
	);

	// row of cordic cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		snu_cell #(
			.W     (W),
			.STAGE (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_re     (re_c[i]),
			.in_im     (im_c[i]),
			.in_acc    (acc_c[i]),
			.in_tag    (tag_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_re    (re_c[i+1]),
			.out_im    (im_c[i+1]),
			.out_acc   (acc_c[i+1]),
			.out_tag   (tag_c[i+1])
		);
	end

	// rounding and result register
	snu_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_c[N]),
		.in_ready  (ready_c[N]),
		.in_acc    (acc_c[N]),
		.in_tag    (tag_c[N]),
		.out_valid (tex.valid),
		.out_ready (tex.ready),
		.tex_u     (tex.tex_u),
		.tex_v     (tex.tex_v)
	);

endmodule

`default_nettype wire
